>>> rtl/rfp_pkg.sv
// Shared constants and types for the radar target frame parser.
package rfp_pkg;

  localparam int NUM_TARGETS = 3;

  localparam int HDR_LEN     = 4;
  localparam int SLOT_BYTES  = 8;
  localparam int PAYLOAD_LEN = SLOT_BYTES * NUM_TARGETS;
  localparam int FOOTER_POS  = HDR_LEN + PAYLOAD_LEN;
  localparam int FRAME_TOTAL = FOOTER_POS + 2;

  localparam int PosW      = $clog2(FRAME_TOTAL);
  localparam int StoreIdxW = $clog2(PAYLOAD_LEN);
  localparam int TgtIdxW   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int CntW      = $clog2(NUM_TARGETS + 1);

  localparam logic [7:0] HDR_B0  = 8'hAA;
  localparam logic [7:0] HDR_B1  = 8'hFF;
  localparam logic [7:0] HDR_B2  = 8'h03;
  localparam logic [7:0] HDR_B3  = 8'h00;
  localparam logic [7:0] FTR_B0  = 8'h55;
  localparam logic [7:0] FTR_B1  = 8'hCC;

  localparam logic [15:0] MAG_MASK = 16'h7FFF;

  // Raw little-endian words of one target slot
  typedef struct packed {
    logic [15:0] res;
    logic [15:0] spd;
    logic [15:0] y;
    logic [15:0] x;
  } slot_t;

  // Frame handed from the parser to the result buffer
  typedef struct packed {
    logic                          done;
    slot_t [NUM_TARGETS-1:0]       slots;
    logic  [NUM_TARGETS-1:0]       valid;
    logic  [CntW-1:0]              count;
  } frame_t;

endpackage

>>> rtl/radar_target_frame_parser_core.sv
// Top level of the radar target frame parser.
//
// Usage:
//   Input channel (data_valid_i / data_ready_o / data_byte_i) carries one
//   link byte per beat. The parser hunts for header AA FF 03 00, captures
//   24 payload bytes and checks footer 55 CC (30 bytes per frame).
//   A good frame yields three result beats on the output channel
//   (result_valid_o / result_ready_i), one per target slot, in slot order;
//   last_target_o marks the third. A bad footer yields nothing.
// Output: the last footer byte loads the frame buffer, which loads the first
//   beat into the output register; next beats follow one per cycle if taken.
// Throughput: one byte per cycle. The only input stall is on the last
//   footer byte while results of the previous frame are still buffered,
//   which can happen only when the receiver holds off the result beats.
// Stalls: a registered output plus a three-slot frame buffer decouple the
//   two sides; the buffer holds raw slot words and decodes one slot per beat.
// Reset: asynchronous, active low; clears the hunt position, footer flag,
//   frame buffer flag and index, output valid. Payload bytes are not cleared.
module radar_target_frame_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               data_valid_i,
  output logic               data_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic [1:0]         target_index_o,
  output logic               target_valid_o,
  output logic signed [15:0] x_mm_o,
  output logic signed [15:0] y_mm_o,
  output logic signed [15:0] velocity_cms_o,
  output logic [15:0]        resolution_mm_o,
  output logic [1:0]         valid_count_o,
  output logic               last_target_o
);
  import rfp_pkg::*;

  localparam int IdxExtW = TgtIdxW + 2;
  localparam int CntExtW = CntW + 2;

  logic   beat;
  logic   at_tail;
  frame_t frame;

  // Frame buffer: raw slots of the frame being emitted
  logic                    buf_valid_q;
  logic [TgtIdxW-1:0]      buf_idx_q;
  slot_t [NUM_TARGETS-1:0] buf_slots_q;
  logic [NUM_TARGETS-1:0]  buf_tv_q;
  logic [CntW-1:0]         buf_cnt_q;
  logic                    buf_last;
  logic                    out_load;

  // Output register
  logic               out_valid_q;
  logic [1:0]         idx_q;
  logic               tv_q;
  logic signed [15:0] x_q, y_q, spd_q;
  logic [15:0]        res_q;
  logic [1:0]         cnt_q;
  logic               last_q;

  logic signed [15:0] x_d, y_d, spd_d;
  logic [15:0]        res_d;
  logic [IdxExtW-1:0] idx_ext;
  logic [CntExtW-1:0] cnt_ext;

  // hold the byte that would complete a frame until the buffer is free
  assign data_ready_o = !(buf_valid_q && at_tail);
  assign beat         = data_valid_i && data_ready_o;

  rfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .byte_i    (data_byte_i),
    .at_tail_o (at_tail),
    .frame_o   (frame)
  );

  rfp_decode u_decode (
    .slot_i (buf_slots_q[buf_idx_q]),
    .x_o    (x_d),
    .y_o    (y_d),
    .spd_o  (spd_d),
    .res_o  (res_d)
  );

  assign buf_last = buf_idx_q == TgtIdxW'(NUM_TARGETS - 1);
  assign out_load = buf_valid_q && (!out_valid_q || result_ready_i);
  assign idx_ext  = IdxExtW'(buf_idx_q);
  assign cnt_ext  = CntExtW'(buf_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      buf_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (frame.done) begin
        buf_valid_q <= 1'b1;
        buf_idx_q   <= '0;
      end else if (out_load) begin
        if (buf_last) begin
          buf_valid_q <= 1'b0;
          buf_idx_q   <= '0;
        end else begin
          buf_idx_q <= buf_idx_q + TgtIdxW'(1);
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (result_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame.done) begin
      buf_slots_q <= frame.slots;
      buf_tv_q    <= frame.valid;
      buf_cnt_q   <= frame.count;
    end
    if (out_load) begin
      idx_q  <= idx_ext[1:0];
      tv_q   <= buf_tv_q[buf_idx_q];
      x_q    <= x_d;
      y_q    <= y_d;
      spd_q  <= spd_d;
      res_q  <= res_d;
      cnt_q  <= cnt_ext[1:0];
      last_q <= buf_last;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign target_index_o  = idx_q;
  assign target_valid_o  = tv_q;
  assign x_mm_o          = x_q;
  assign y_mm_o          = y_q;
  assign velocity_cms_o  = spd_q;
  assign resolution_mm_o = res_q;
  assign valid_count_o   = cnt_q;
  assign last_target_o   = last_q;

endmodule

>>> rtl/rfp_parser.sv
// Byte-level frame sync: header hunt, payload capture and footer check.
module rfp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    byte_i,
  output logic          at_tail_o,
  output rfp_pkg::frame_t frame_o
);
  import rfp_pkg::*;

  logic [PosW-1:0]      pos_q, pos_d;
  logic                 ftr_ok_q, ftr_ok_d;
  logic [7:0]           store_q [PAYLOAD_LEN];
  logic [PosW-1:0]      off;
  logic [StoreIdxW-1:0] store_idx;
  logic                 in_hdr, in_payload, at_ftr0, at_tail;
  logic [7:0]           hdr_exp;

  assign in_hdr     = pos_q < PosW'(HDR_LEN);
  assign in_payload = !in_hdr && (pos_q < PosW'(FOOTER_POS));
  assign at_ftr0    = pos_q == PosW'(FOOTER_POS);
  assign at_tail    = pos_q == PosW'(FRAME_TOTAL - 1);
  assign at_tail_o  = at_tail;

  assign off       = pos_q - PosW'(HDR_LEN);
  assign store_idx = off[StoreIdxW-1:0];

  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    hdr_exp = HDR_B0;
      2'd1:    hdr_exp = HDR_B1;
      2'd2:    hdr_exp = HDR_B2;
      default: hdr_exp = HDR_B3;
    endcase
  end

  always_comb begin
    pos_d    = pos_q;
    ftr_ok_d = ftr_ok_q;
    if (beat_i) begin
      priority if (in_hdr) begin
        if (byte_i == hdr_exp) pos_d = pos_q + PosW'(1);
        else pos_d = (byte_i == HDR_B0) ? PosW'(1) : '0;
      end else if (in_payload) begin
        pos_d = pos_q + PosW'(1);
      end else if (at_ftr0) begin
        ftr_ok_d = byte_i == FTR_B0;
        pos_d    = pos_q + PosW'(1);
      end else begin
        ftr_ok_d = 1'b0;
        pos_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ftr_ok_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      ftr_ok_q <= ftr_ok_d;
    end
  end

  // payload bytes, no reset: every entry is rewritten before a frame decodes
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      if (beat_i && in_payload && store_idx == StoreIdxW'(k)) store_q[k] <= byte_i;
    end
  end

  always_comb begin
    frame_o.count = '0;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      frame_o.slots[i].x   = {store_q[SLOT_BYTES*i+1], store_q[SLOT_BYTES*i]};
      frame_o.slots[i].y   = {store_q[SLOT_BYTES*i+3], store_q[SLOT_BYTES*i+2]};
      frame_o.slots[i].spd = {store_q[SLOT_BYTES*i+5], store_q[SLOT_BYTES*i+4]};
      frame_o.slots[i].res = {store_q[SLOT_BYTES*i+7], store_q[SLOT_BYTES*i+6]};
      frame_o.valid[i] = |{frame_o.slots[i].x, frame_o.slots[i].y, frame_o.slots[i].spd};
      frame_o.count    = frame_o.count + CntW'(frame_o.valid[i]);
    end
    frame_o.done = beat_i && at_tail && ftr_ok_q && (byte_i == FTR_B1);
  end

endmodule

>>> rtl/rfp_decode.sv
// Sign-magnitude decode of one target slot.
module rfp_decode (
  input  rfp_pkg::slot_t      slot_i,
  output logic signed [15:0]  x_o,
  output logic signed [15:0]  y_o,
  output logic signed [15:0]  spd_o,
  output logic        [15:0]  res_o
);
  import rfp_pkg::*;

  // bit15 set means positive; magnitude in the low 15 bits
  function automatic logic [15:0] sm_dec(input logic [15:0] raw);
    logic [15:0] mag;
    mag = raw & MAG_MASK;
    return raw[15] ? mag : (16'd0 - mag);
  endfunction

  assign x_o   = sm_dec(slot_i.x);
  assign y_o   = sm_dec(slot_i.y);
  assign spd_o = sm_dec(slot_i.spd);
  assign res_o = slot_i.res;

endmodule

>>> rtl/rfp_checker.sv
// Port-level checks for the radar target frame parser, bound to the top.
module rfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               result_valid_o,
  input logic               result_ready_i,
  input logic [1:0]         target_index_o,
  input logic               target_valid_o,
  input logic signed [15:0] x_mm_o,
  input logic signed [15:0] y_mm_o,
  input logic signed [15:0] velocity_cms_o,
  input logic [15:0]        resolution_mm_o,
  input logic [1:0]         valid_count_o,
  input logic               last_target_o
);
  import rfp_pkg::*;

  localparam int LastW = TgtIdxW + 2;
  localparam logic [LastW-1:0] LastIdx = LastW'(NUM_TARGETS - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o &&
      $stable(target_index_o) && $stable(target_valid_o) &&
      $stable(x_mm_o) && $stable(y_mm_o) && $stable(velocity_cms_o) &&
      $stable(resolution_mm_o) && $stable(valid_count_o) && $stable(last_target_o))
    else $error("result beat dropped or changed under stall");

  // beats of one frame come back to back with rising slot index
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && !last_target_o |=> result_valid_o &&
      target_index_o == $past(target_index_o) + 2'd1)
    else $error("slot sequence broken");

  // last flag only on the final slot
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_target_o |-> target_index_o == LastIdx[1:0])
    else $error("last flag on wrong slot");

  // valid count is one value per frame
  a_cnt_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && !last_target_o |=>
      valid_count_o == $past(valid_count_o))
    else $error("valid count changed within a frame");

endmodule

bind radar_target_frame_parser_core rfp_checker u_rfp_checker (.*);
